// ----- hw/rtl/bba_pkg.sv -----
// bba_pkg: shared types and constants for the bitmap block allocator
// field widths, status and opcode codes, register indexes, payload structs
// no dependencies; imported by bba_divider and bitmap_block_allocator
package bba_pkg;

  // fixed field widths
  localparam int OFF_W     = 22;
  localparam int COUNT_W   = 11;
  localparam int BYTES_W   = 13;
  localparam int STRAT_W   = 2;
  localparam int CFG_IDX_W = 2;

  // block size saturation and largest count the count field holds
  localparam logic [BYTES_W-1:0] BYTES_CAP = 13'd4096;
  localparam int                 COUNT_MAX = 2047;

  // register reset values
  localparam logic [STRAT_W-1:0] STRAT_RST = 2'd0;
  localparam logic [COUNT_W-1:0] COUNT_RST = 11'd1024;
  localparam logic [BYTES_W-1:0] BYTES_RST = 13'd8;

  typedef enum logic {
    OP_ALLOC = 1'b0,
    OP_FREE  = 1'b1
  } bba_op_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_FULL     = 2'd1,
    ST_BAD_FREE = 2'd2
  } bba_status_e;

  // allocation strategy codes
  localparam logic [STRAT_W-1:0] STRAT_FIRST = 2'd0;
  localparam logic [STRAT_W-1:0] STRAT_BEST  = 2'd1;
  localparam logic [STRAT_W-1:0] STRAT_BUMP  = 2'd2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_STRATEGY    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_COUNT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_BYTES = 2'd2;

  // request and result payloads
  typedef struct packed {
    bba_op_e          opcode;
    logic [OFF_W-1:0] free_offset;
  } bba_req_t;

  typedef struct packed {
    bba_status_e        status;
    logic [OFF_W-1:0]   block_offset;
    logic [COUNT_W-1:0] free_count;
  } bba_rsp_t;

  // divider command and response
  typedef struct packed {
    logic               start;
    logic [OFF_W-1:0]   dividend;
    logic [BYTES_W-1:0] divisor;
  } bba_div_req_t;

  typedef struct packed {
    logic               done;
    logic [OFF_W-1:0]   quot;
    logic [BYTES_W-1:0] rem;
  } bba_div_rsp_t;

endpackage

// ----- hw/rtl/bitmap_block_allocator.sv -----
// bitmap_block_allocator: fixed-block pool allocator over a bitmap memory
// sequencer, first-fit word scan and bump pointer; uses bba_map_mem, bba_divider
// depends on bba_pkg
//
//   channel   ports                                  transaction
//   request   start_i, busy_o, req_i                 start_i high while busy_o low
//   result    done_o, rsp_o                          done_o high for one cycle
//   config    cfg_we_i, cfg_idx_i, cfg_wdata_i       cfg_we_i high, no wait
//
// first-fit and best-fit allocate: scan the bitmap with one bitmap word read per cycle
// bump allocate: bump pointer, then offset; no free block: answered from idle
// free: one pass through the bit-serial divider, then the word fetch and bit
// check; a free that fails the range or alignment check ends after the divider
// reset and every write to the strategy, block count or block size register
// start a clearing pass and the block size rounding, with busy_o high throughout
// results cannot be stalled; one transaction is in flight at a time
module bitmap_block_allocator #(
  parameter int MAX_BLOCKS    = 1024,
  parameter int ALIGN_BYTES   = 8,
  parameter int MAP_WORD_BITS = 32
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  output logic                              busy_o,
  input  bba_pkg::bba_req_t                 req_i,
  output logic                              done_o,
  output bba_pkg::bba_rsp_t                 rsp_o,
  input  logic                              cfg_we_i,
  input  logic [bba_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [bba_pkg::BYTES_W-1:0]       cfg_wdata_i
);
  import bba_pkg::*;

  localparam int MAP_WORDS = (MAX_BLOCKS + MAP_WORD_BITS - 1) / MAP_WORD_BITS;
  localparam int ADDR_W    = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
  localparam int CTR_W     = $clog2(MAP_WORDS + 1);
  localparam int BIT_W     = $clog2(MAP_WORD_BITS);
  localparam int IDX_W     = $clog2(MAP_WORDS * MAP_WORD_BITS);
  localparam int CMP_W     = (IDX_W > COUNT_W) ? IDX_W : COUNT_W;
  localparam int CAP       = (MAX_BLOCKS > COUNT_MAX) ? COUNT_MAX : MAX_BLOCKS;
  localparam int PROD_W    = COUNT_W + BYTES_W;

  // reciprocal constants for the divisions by the alignment and by the word width
  localparam int AL_SH  = BYTES_W + $clog2(ALIGN_BYTES);
  localparam int AL_MUL = ((1 << AL_SH) + ALIGN_BYTES - 1) / ALIGN_BYTES;
  localparam int AL_PW  = 2 * BYTES_W + 1;
  localparam int WB_SH  = COUNT_W + BIT_W;
  localparam int WB_MUL = ((1 << WB_SH) + MAP_WORD_BITS - 1) / MAP_WORD_BITS;
  localparam int WB_PW  = 2 * COUNT_W + 1;

  localparam logic [COUNT_W-1:0] CAP_C     = COUNT_W'(CAP);
  localparam logic [CTR_W-1:0]   LAST_WORD = CTR_W'(MAP_WORDS - 1);
  localparam logic [CTR_W-1:0]   WORDS_C   = CTR_W'(MAP_WORDS);
  localparam logic [BYTES_W-1:0] ALIGN_C   = BYTES_W'(ALIGN_BYTES);
  localparam logic [BYTES_W-1:0] ALIGN_M1  = BYTES_W'(ALIGN_BYTES - 1);

  // sequencer states
  localparam logic [3:0] S_INIT_CLR  = 4'd0;
  localparam logic [3:0] S_INIT_DIV  = 4'd1;
  localparam logic [3:0] S_IDLE      = 4'd3;
  localparam logic [3:0] S_SCAN      = 4'd4;
  localparam logic [3:0] S_SET       = 4'd5;
  localparam logic [3:0] S_MUL       = 4'd6;
  localparam logic [3:0] S_FDIV1     = 4'd7;
  localparam logic [3:0] S_FDIV2     = 4'd8;
  localparam logic [3:0] S_FCHK      = 4'd9;

  logic [3:0]               state_q, state_d;
  logic [STRAT_W-1:0]       strat_q, strat_d;
  logic [COUNT_W-1:0]       blk_cnt_q, blk_cnt_d;
  logic [BYTES_W-1:0]       blk_bytes_q, blk_bytes_d;
  logic [BYTES_W-1:0]       size_q, size_d;
  logic [COUNT_W-1:0]       free_q, free_d;
  logic [COUNT_W-1:0]       bump_q, bump_d;
  logic [CTR_W-1:0]         ctr_q, ctr_d;
  logic                     pend_q, pend_d;
  logic [ADDR_W-1:0]        rd_word_q, rd_word_d;
  logic [ADDR_W-1:0]        hit_word_q, hit_word_d;
  logic [BIT_W-1:0]         hit_bit_q, hit_bit_d;
  logic [MAP_WORD_BITS-1:0] hit_data_q, hit_data_d;
  logic [COUNT_W-1:0]       idx_q, idx_d;
  logic                     done_q, done_d;
  bba_rsp_t                 rsp_q, rsp_d;

  logic                     mem_we;
  logic [ADDR_W-1:0]        mem_waddr;
  logic [MAP_WORD_BITS-1:0] mem_wdata;
  logic                     mem_re;
  logic [ADDR_W-1:0]        mem_raddr;
  logic [MAP_WORD_BITS-1:0] mem_rdata;

  bba_div_req_t             div_req;
  bba_div_rsp_t             div_rsp;

  logic [COUNT_W-1:0]       count_live;
  logic [BYTES_W-1:0]       bytes_eff;
  logic                     word_hit;
  logic [BIT_W-1:0]         word_bit;
  logic [IDX_W-1:0]         idx_full;
  logic [PROD_W-1:0]        prod;

  logic [BYTES_W-1:0]       size_sum;
  logic [AL_PW-1:0]         size_prod;
  logic [BYTES_W-1:0]       size_quot;
  logic [BYTES_W-1:0]       size_round;
  logic [WB_PW-1:0]         map_prod;
  logic [COUNT_W-1:0]       map_word;
  logic [COUNT_W-1:0]       map_bit;

  // bitmap storage
  bba_map_mem #(
    .DEPTH  (MAP_WORDS),
    .WIDTH  (MAP_WORD_BITS),
    .ADDR_W (ADDR_W)
  ) u_map_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // divider for offset to block index
  bba_divider u_divider (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // effective pool geometry
  always_comb begin
    count_live = (blk_cnt_q > CAP_C) ? CAP_C : blk_cnt_q;
    if (blk_bytes_q == '0) begin
      bytes_eff = BYTES_W'(1);
    end else if (blk_bytes_q > BYTES_CAP) begin
      bytes_eff = BYTES_CAP;
    end else begin
      bytes_eff = blk_bytes_q;
    end
  end

  // block size rounded up to the alignment, block index split into word and bit
  always_comb begin
    size_sum   = bytes_eff + ALIGN_M1;
    size_prod  = AL_PW'(size_sum) * AL_PW'(AL_MUL);
    size_quot  = BYTES_W'(size_prod >> AL_SH);
    size_round = size_quot * ALIGN_C;
    map_prod   = WB_PW'(idx_q) * WB_PW'(WB_MUL);
    map_word   = COUNT_W'(map_prod >> WB_SH);
    map_bit    = idx_q - map_word * COUNT_W'(MAP_WORD_BITS);
  end

  // lowest clear bit of the word just read
  always_comb begin
    word_hit = 1'b0;
    word_bit = '0;
    for (int i = MAP_WORD_BITS - 1; i >= 0; i--) begin
      if (!mem_rdata[i]) begin
        word_hit = 1'b1;
        word_bit = BIT_W'(i);
      end
    end
  end

  // block index of the found bit and byte offset of the granted block
  always_comb begin
    idx_full = IDX_W'(hit_word_q) * IDX_W'(MAP_WORD_BITS) + IDX_W'(hit_bit_q);
    prod     = PROD_W'(idx_q) * PROD_W'(size_q);
  end

  // sequencer
  always_comb begin
    state_d     = state_q;
    strat_d     = strat_q;
    blk_cnt_d   = blk_cnt_q;
    blk_bytes_d = blk_bytes_q;
    size_d      = size_q;
    free_d      = free_q;
    bump_d      = bump_q;
    ctr_d       = ctr_q;
    pend_d      = pend_q;
    rd_word_d   = rd_word_q;
    hit_word_d  = hit_word_q;
    hit_bit_d   = hit_bit_q;
    hit_data_d  = hit_data_q;
    idx_d       = idx_q;
    done_d      = 1'b0;
    rsp_d       = rsp_q;

    mem_we    = 1'b0;
    mem_waddr = hit_word_q;
    mem_wdata = hit_data_q | (MAP_WORD_BITS'(1) << hit_bit_q);
    mem_re    = 1'b0;
    mem_raddr = ctr_q[ADDR_W-1:0];

    div_req.start    = 1'b0;
    div_req.dividend = req_i.free_offset;
    div_req.divisor  = size_q;

    case (state_q)
      // clear the bitmap one word per cycle
      S_INIT_CLR: begin
        mem_we    = 1'b1;
        mem_waddr = ctr_q[ADDR_W-1:0];
        mem_wdata = '0;
        if (ctr_q == LAST_WORD) begin
          ctr_d   = '0;
          state_d = S_INIT_DIV;
        end else begin
          ctr_d = ctr_q + 1'b1;
        end
      end
      // take the rounded block size and refill the pool
      S_INIT_DIV: begin
        size_d  = size_round;
        free_d  = count_live;
        bump_d  = '0;
        state_d = S_IDLE;
      end
      // take a new transaction
      S_IDLE: begin
        if (start_i) begin
          rsp_d.block_offset = '0;
          rsp_d.free_count   = free_q;
          if (req_i.opcode == OP_FREE) begin
            div_req.start = 1'b1;
            state_d       = S_FDIV1;
          end else if (free_q == '0) begin
            done_d       = 1'b1;
            rsp_d.status = ST_FULL;
          end else if (strat_q == STRAT_FIRST || strat_q == STRAT_BEST) begin
            ctr_d   = '0;
            pend_d  = 1'b0;
            state_d = S_SCAN;
          end else if (strat_q == STRAT_BUMP && bump_q < count_live) begin
            idx_d   = bump_q;
            bump_d  = bump_q + 1'b1;
            free_d  = free_q - 1'b1;
            state_d = S_MUL;
          end else begin
            done_d       = 1'b1;
            rsp_d.status = ST_FULL;
          end
        end
      end
      // read words in order, test the word read the cycle before
      S_SCAN: begin
        if (pend_q && word_hit) begin
          hit_word_d = rd_word_q;
          hit_bit_d  = word_bit;
          hit_data_d = mem_rdata;
          pend_d     = 1'b0;
          state_d    = S_SET;
        end else if (ctr_q != WORDS_C) begin
          mem_re    = 1'b1;
          rd_word_d = ctr_q[ADDR_W-1:0];
          ctr_d     = ctr_q + 1'b1;
          pend_d    = 1'b1;
        end else begin
          pend_d = 1'b0;
          if (!pend_q) begin
            done_d             = 1'b1;
            rsp_d.status       = ST_FULL;
            rsp_d.block_offset = '0;
            rsp_d.free_count   = free_q;
            state_d            = S_IDLE;
          end
        end
      end
      // mark the found block as used if it lies inside the pool
      S_SET: begin
        if (CMP_W'(idx_full) < CMP_W'(count_live)) begin
          mem_we  = 1'b1;
          idx_d   = COUNT_W'(idx_full);
          free_d  = free_q - 1'b1;
          state_d = S_MUL;
        end else begin
          done_d             = 1'b1;
          rsp_d.status       = ST_FULL;
          rsp_d.block_offset = '0;
          rsp_d.free_count   = free_q;
          state_d            = S_IDLE;
        end
      end
      // byte offset of the granted block
      S_MUL: begin
        done_d             = 1'b1;
        rsp_d.status       = ST_OK;
        rsp_d.block_offset = prod[OFF_W-1:0];
        rsp_d.free_count   = free_q;
        state_d            = S_IDLE;
      end
      // offset to block index: range and alignment checks
      S_FDIV1: begin
        if (div_rsp.done) begin
          if (div_rsp.rem != '0 || div_rsp.quot >= OFF_W'(count_live)) begin
            done_d       = 1'b1;
            rsp_d.status = ST_BAD_FREE;
            state_d      = S_IDLE;
          end else begin
            idx_d   = COUNT_W'(div_rsp.quot);
            state_d = S_FDIV2;
          end
        end
      end
      // block index to word and bit, fetch the word
      S_FDIV2: begin
        hit_word_d = ADDR_W'(map_word);
        hit_bit_d  = BIT_W'(map_bit);
        mem_re     = 1'b1;
        mem_raddr  = ADDR_W'(map_word);
        state_d    = S_FCHK;
      end
      // release the block if its bit is set
      S_FCHK: begin
        done_d  = 1'b1;
        state_d = S_IDLE;
        if (mem_rdata[hit_bit_q]) begin
          mem_we           = 1'b1;
          mem_wdata        = mem_rdata & ~(MAP_WORD_BITS'(1) << hit_bit_q);
          free_d           = free_q + 1'b1;
          rsp_d.status     = ST_OK;
          rsp_d.free_count = free_q + 1'b1;
        end else begin
          rsp_d.status = ST_BAD_FREE;
        end
      end
      default: begin
        ctr_d   = '0;
        state_d = S_INIT_CLR;
      end
    endcase

    // writes to the strategy, block count and block size registers rebuild the pool
    if (cfg_we_i) begin
      if (cfg_idx_i == CFG_STRATEGY || cfg_idx_i == CFG_BLOCK_COUNT ||
          cfg_idx_i == CFG_BLOCK_BYTES) begin
        ctr_d   = '0;
        pend_d  = 1'b0;
        state_d = S_INIT_CLR;
      end
      case (cfg_idx_i)
        CFG_STRATEGY:    strat_d     = cfg_wdata_i[STRAT_W-1:0];
        CFG_BLOCK_COUNT: blk_cnt_d   = cfg_wdata_i[COUNT_W-1:0];
        CFG_BLOCK_BYTES: blk_bytes_d = cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_INIT_CLR;
      strat_q     <= STRAT_RST;
      blk_cnt_q   <= COUNT_RST;
      blk_bytes_q <= BYTES_RST;
      free_q      <= '0;
      bump_q      <= '0;
      ctr_q       <= '0;
      pend_q      <= 1'b0;
      done_q      <= 1'b0;
    end else begin
      state_q     <= state_d;
      strat_q     <= strat_d;
      blk_cnt_q   <= blk_cnt_d;
      blk_bytes_q <= blk_bytes_d;
      free_q      <= free_d;
      bump_q      <= bump_d;
      ctr_q       <= ctr_d;
      pend_q      <= pend_d;
      done_q      <= done_d;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    size_q     <= size_d;
    rd_word_q  <= rd_word_d;
    hit_word_q <= hit_word_d;
    hit_bit_q  <= hit_bit_d;
    hit_data_q <= hit_data_d;
    idx_q      <= idx_d;
    rsp_q      <= rsp_d;
  end

  assign busy_o = (state_q != S_IDLE);
  assign done_o = done_q;
  assign rsp_o  = rsp_q;

`ifndef NO_ASSERTIONS
  // free count never exceeds the pool size while waiting for work
  a_free_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |-> (free_q <= count_live))
    else $error("free count above pool size");

  // an accepted transaction either completes at once or keeps the block busy
  a_accept_progress: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> (busy_o || done_o))
    else $error("accepted transaction lost");

  // allocation only sets a bit that was clear
  a_set_clear_bit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mem_we && state_q == S_SET) |-> !hit_data_q[hit_bit_q])
    else $error("allocation of a used block");
`endif

endmodule

// ----- hw/rtl/bba_map_mem.sv -----
// bba_map_mem: bitmap word memory, one write port and one read port
// read data is registered, ready in the cycle after re_i
// no dependencies
module bba_map_mem #(
  parameter int DEPTH  = 32,
  parameter int WIDTH  = 32,
  parameter int ADDR_W = 5
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [WIDTH-1:0]  wdata_i,
  input  logic              re_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- hw/rtl/bba_divider.sv -----
// bba_divider: restoring divider, one quotient bit per cycle
// 22-bit dividend by 13-bit divisor, done pulses once the last quotient bit is in
// depends on bba_pkg
module bba_divider (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  bba_pkg::bba_div_req_t req_i,
  output bba_pkg::bba_div_rsp_t rsp_o
);
  import bba_pkg::*;

  localparam int CNT_W = $clog2(OFF_W + 1);

  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic               done_q, done_d;
  logic [OFF_W-1:0]   quo_q, quo_d;
  logic [BYTES_W-1:0] rem_q, rem_d;
  logic [BYTES_W-1:0] dvs_q, dvs_d;
  logic [BYTES_W:0]   rem_sh;
  logic [BYTES_W:0]   rem_sub;
  logic               ge;

  // one restoring step
  always_comb begin
    rem_sh  = {rem_q, quo_q[OFF_W-1]};
    rem_sub = rem_sh - {1'b0, dvs_q};
    ge      = (rem_sh >= {1'b0, dvs_q});
  end

  // sequencing of load and steps
  always_comb begin
    cnt_d  = cnt_q;
    done_d = 1'b0;
    quo_d  = quo_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    if (req_i.start) begin
      cnt_d = CNT_W'(OFF_W);
      quo_d = req_i.dividend;
      rem_d = '0;
      dvs_d = req_i.divisor;
    end else if (cnt_q != '0) begin
      cnt_d  = cnt_q - 1'b1;
      done_d = (cnt_q == CNT_W'(1));
      quo_d  = {quo_q[OFF_W-2:0], ge};
      rem_d  = ge ? rem_sub[BYTES_W-1:0] : rem_sh[BYTES_W-1:0];
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      done_q <= done_d;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quot = quo_q;
  assign rsp_o.rem  = rem_q;

endmodule
